// ===== rtl/wchp_pkg.sv =====
// Package: item types, parse phases, status codes and tag constants for the WAV header parser.
package wchp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_CID   = 4'd3,
    PH_CSIZE = 4'd4,
    PH_FMT   = 4'd5,
    PH_SKIP  = 4'd6,
    PH_BAD   = 4'd7,
    PH_WAIT  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNSUPP    = 3'd1,
    ST_BAD_TAGS  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_FIELD_BYTES = 32'd16;
  localparam logic [15:0] FMT_FLOAT       = 16'd3;
  localparam logic [15:0] FMT_FLOAT_BITS  = 16'd32;
  localparam logic [15:0] MONO_CHANNELS   = 16'd1;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_bytes;
    logic [31:0] data_offset;
    logic [29:0] float_count;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

// ===== rtl/wchp_parser.sv =====
// Parser: per-byte phase tracking, field capture and result formation.
module wchp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  wchp_pkg::in_item_t in_item_i,
  output wchp_pkg::result_t  result_o
);
  import wchp_pkg::*;

  localparam logic [3:0] WORD_LAST = 4'd3;
  localparam logic [3:0] FMT_LAST  = 4'(FMT_FIELD_BYTES - 32'd1);

  phase_e      phase_q, phase_d;
  logic [31:0] byte_pos_q, byte_pos_d;
  logic [31:0] skip_q, skip_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [15:0] fmt_code_q, fmt_code_d;
  logic [15:0] chans_q, chans_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] dsize_q, dsize_d;
  logic [31:0] doff_q, doff_d;
  logic        found_fmt_q, found_fmt_d;
  logic        found_data_q, found_data_d;
  logic        riff_ok_q, riff_ok_d;

  logic [7:0]  b;
  logic [31:0] tag_n, len_n;
  logic        complete;
  status_e     full_status;

  assign b     = in_item_i.file_byte;
  assign tag_n = {b, tag_q[31:8]};
  assign len_n = {b, len_q[31:8]};

  always_comb begin
    phase_d      = phase_q;
    byte_pos_d   = byte_pos_q;
    skip_d       = skip_q;
    idx_d        = idx_q;
    tag_d        = tag_q;
    len_d        = len_q;
    fmt_code_d   = fmt_code_q;
    chans_d      = chans_q;
    rate_d       = rate_q;
    bits_d       = bits_q;
    dsize_d      = dsize_q;
    doff_d       = doff_q;
    found_fmt_d  = found_fmt_q;
    found_data_d = found_data_q;
    riff_ok_d    = riff_ok_q;
    complete     = 1'b0;

    case (phase_q)
      PH_RIFF, PH_WAVE, PH_CID: begin
        tag_d = tag_n;
        idx_d = idx_q + 4'd1;
        if (idx_q == WORD_LAST) begin
          idx_d = '0;
          case (phase_q)
            PH_RIFF: begin
              riff_ok_d = (tag_n == TAG_RIFF);
              phase_d   = PH_RSIZE;
            end
            PH_WAVE: phase_d = (riff_ok_q && tag_n == TAG_WAVE) ? PH_CID : PH_BAD;
            default: phase_d = PH_CSIZE;
          endcase
        end
      end
      PH_RSIZE, PH_CSIZE: begin
        len_d = len_n;
        idx_d = idx_q + 4'd1;
        if (idx_q == WORD_LAST) begin
          idx_d = '0;
          if (phase_q == PH_RSIZE) begin
            phase_d = PH_WAVE;
          end else if (tag_q == TAG_FMT) begin
            found_fmt_d = 1'b1;
            fmt_code_d  = '0;
            chans_d     = '0;
            rate_d      = '0;
            bits_d      = '0;
            skip_d      = (len_n > FMT_FIELD_BYTES) ? len_n - FMT_FIELD_BYTES : '0;
            phase_d     = PH_FMT;
          end else if (tag_q == TAG_DATA) begin
            found_data_d = 1'b1;
            dsize_d      = len_n;
            doff_d       = byte_pos_q + 32'd1;
            if (found_fmt_q) begin
              complete = 1'b1;
            end else begin
              skip_d  = len_n;
              phase_d = (len_n != '0) ? PH_SKIP : PH_CID;
            end
          end else begin
            skip_d  = len_n;
            phase_d = (len_n != '0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_FMT: begin
        case (idx_q)
          4'd0:    fmt_code_d[7:0]  = b;
          4'd1:    fmt_code_d[15:8] = b;
          4'd2:    chans_d[7:0]     = b;
          4'd3:    chans_d[15:8]    = b;
          4'd4, 4'd5, 4'd6, 4'd7: rate_d[{idx_q[1:0], 3'b000} +: 8] = b;
          4'd14:   bits_d[7:0]      = b;
          4'd15:   bits_d[15:8]     = b;
          default: ;
        endcase
        idx_d = idx_q + 4'd1;
        if (idx_q == FMT_LAST) begin
          idx_d = '0;
          if (found_data_q) begin
            complete = 1'b1;
          end else begin
            phase_d = (skip_q != '0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_SKIP: begin
        skip_d = (skip_q != '0) ? skip_q - 32'd1 : skip_q;
        if (skip_d == '0) begin
          phase_d = PH_CID;
        end
      end
      default: ;
    endcase

    byte_pos_d = byte_pos_q + 32'd1;
    if (complete) begin
      phase_d = PH_WAIT;
    end
  end

  always_comb begin
    if (fmt_code_d != FMT_FLOAT || chans_d != MONO_CHANNELS || bits_d != FMT_FLOAT_BITS) begin
      full_status = ST_UNSUPP;
    end else if (dsize_d == '0) begin
      full_status = ST_EMPTY;
    end else begin
      full_status = ST_OK;
    end
  end

  always_comb begin
    result_o = '0;
    if (accept_i) begin
      if (complete) begin
        result_o.valid              = 1'b1;
        result_o.item.status        = full_status;
        result_o.item.audio_format  = fmt_code_d;
        result_o.item.channel_count = chans_d;
        result_o.item.sample_rate   = rate_d;
        result_o.item.sample_bits   = bits_d;
        result_o.item.data_bytes    = dsize_d;
        result_o.item.data_offset   = doff_d;
        result_o.item.float_count   = dsize_d[31:2];
      end else if (in_item_i.last_byte && phase_d != PH_WAIT) begin
        result_o.valid       = 1'b1;
        result_o.item.status = (phase_d == PH_BAD) ? ST_BAD_TAGS : ST_TRUNCATED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_RIFF;
      byte_pos_q   <= '0;
      skip_q       <= '0;
      idx_q        <= '0;
      tag_q        <= '0;
      len_q        <= '0;
      fmt_code_q   <= '0;
      chans_q      <= '0;
      rate_q       <= '0;
      bits_q       <= '0;
      dsize_q      <= '0;
      doff_q       <= '0;
      found_fmt_q  <= 1'b0;
      found_data_q <= 1'b0;
      riff_ok_q    <= 1'b0;
    end else if (accept_i && in_item_i.last_byte) begin
      phase_q      <= PH_RIFF;
      byte_pos_q   <= '0;
      skip_q       <= '0;
      idx_q        <= '0;
      tag_q        <= '0;
      len_q        <= '0;
      fmt_code_q   <= '0;
      chans_q      <= '0;
      rate_q       <= '0;
      bits_q       <= '0;
      dsize_q      <= '0;
      doff_q       <= '0;
      found_fmt_q  <= 1'b0;
      found_data_q <= 1'b0;
      riff_ok_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      byte_pos_q   <= byte_pos_d;
      skip_q       <= skip_d;
      idx_q        <= idx_d;
      tag_q        <= tag_d;
      len_q        <= len_d;
      fmt_code_q   <= fmt_code_d;
      chans_q      <= chans_d;
      rate_q       <= rate_d;
      bits_q       <= bits_d;
      dsize_q      <= dsize_d;
      doff_q       <= doff_d;
      found_fmt_q  <= found_fmt_d;
      found_data_q <= found_data_d;
      riff_ok_q    <= riff_ok_d;
    end
  end

  a_wait_has_chunks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT) |-> (found_fmt_q && found_data_q))
    else $error("wait phase without both chunks");

  a_rearm_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_item_i.last_byte) |=> (phase_q == PH_RIFF && byte_pos_q == '0))
    else $error("parser did not rearm after last byte");

  a_result_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> accept_i)
    else $error("result without accepted item");

endmodule

// ===== rtl/wchp_out_buf.sv =====
// Output buffer: result register with a skid stage.
module wchp_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wchp_pkg::result_t   result_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wchp_pkg::out_item_t out_item_o
);
  import wchp_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (pop || !main_valid_q) begin
      main_valid_d = result_i.valid;
      main_d       = result_i.item;
    end else if (result_i.valid) begin
      skid_valid_d = 1'b1;
      skid_d       = result_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid holds an item while output is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_i.valid |-> !skid_valid_q)
    else $error("result pushed into full buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (!skid_valid_q && main_valid_q))
    else $error("skid item not moved to output");

endmodule

// ===== rtl/wav_chunk_header_parser_unit.sv =====
// Top level: WAV RIFF header parser with byte input and buffered result output.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o   | in_item_i  (file_byte, last_byte)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (status .. float_count)
//
// One byte is taken per cycle while in_stall_o is low; the parse state registers update on the accepting edge.
// A result is registered in the output register, or in the skid stage while that is stalled, for out_valid_o.
// Reset returns the parser to the RIFF tag phase and empties the output buffer.
// in_stall_o rises only while both the output register and the skid stage hold results.
module wav_chunk_header_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wchp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wchp_pkg::out_item_t out_item_o
);
  import wchp_pkg::*;

  logic    accept;
  logic    buf_full;
  result_t result;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  wchp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .result_o  (result)
  );

  wchp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sim/tb_wav_chunk_header_parser_unit.sv =====
// Testbench for wav_chunk_header_parser_unit: whole WAV files, byte by byte, checked per header.
`timescale 1ns / 100ps

module tb_wav_chunk_header_parser_unit;
  import wchp_pkg::*;

  typedef struct packed {
    logic        noise;
    logic        riff_bad;
    logic        wave_bad;
    logic        data_first;
    logic        dup;
    logic        has_junk;
    logic [7:0]  junk_len;
    logic [31:0] fmt_len;
    logic [15:0] fmt_code;
    logic [15:0] fmt_ch;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_bits;
    logic [31:0] data_len;
    logic [7:0]  cut;
    logic [7:0]  tail;
    logic        typed;
    out_item_t   want;
  } wav_file_t;

  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam out_item_t NO_WANT = '0;
  localparam out_item_t TRUNC_HDR = '{ST_TRUNCATED, 16'd0, 16'd0, 32'd0, 16'd0, 32'd0,
                                      32'd0, 30'd0};
  localparam out_item_t BADTAG_HDR = '{ST_BAD_TAGS, 16'd0, 16'd0, 32'd0, 16'd0, 32'd0,
                                       32'd0, 30'd0};

  localparam wav_file_t DIRECTED [24] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd0, 8'd5, 1'b1,
      '{ST_OK, 16'd3, 16'd1, 32'd48000, 16'd32, 32'd1024, 32'd44, 30'd256}},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd8000, 16'd32,
      32'd0, 8'd0, 8'd0, 1'b1,
      '{ST_EMPTY, 16'd3, 16'd1, 32'd8000, 16'd32, 32'd0, 32'd44, 30'd0}},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd1, 16'd2, 32'd44100, 16'd16,
      32'd400, 8'd0, 8'd2, 1'b1,
      '{ST_UNSUPP, 16'd1, 16'd2, 32'd44100, 16'd16, 32'd400, 32'd44, 30'd100}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd0, 8'd3, 1'b1, BADTAG_HDR},
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd0, 8'd3, 1'b1, BADTAG_HDR},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd1, 8'd0, 1'b1, TRUNC_HDR},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd5, 8'd0, 1'b1, TRUNC_HDR},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd12, 8'd0, 1'b1, TRUNC_HDR},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd6, 8'd0, 1'b1, TRUNC_HDR},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
      16'hFFFF, 32'hFFFF_FFFF, 8'd0, 8'd2, 1'b1,
      '{ST_UNSUPP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd44,
        30'h3FFF_FFFF}},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd0, 16'd0, 32'd0, 16'd0,
      32'd0, 8'd0, 8'd1, 1'b1,
      '{ST_UNSUPP, 16'd0, 16'd0, 32'd0, 16'd0, 32'd0, 32'd44, 30'd0}},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd22050, 16'd16,
      32'd64, 8'd0, 8'd1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd2, 32'd48000, 16'd32,
      32'd64, 8'd0, 8'd1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd4, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd64, 8'd0, 8'd1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd18, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd12, 8'd0, 8'd2, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 32'hFFFF_FFFF, 16'd3, 16'd1, 32'd16000,
      16'd32, 32'd6, 8'd0, 8'd2, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd16000, 16'd32,
      32'd0, 8'd0, 8'd1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd80, 8'd0, 8'd1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd9, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd80, 8'd0, 8'd1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd32000, 16'd32,
      32'd40, 8'd0, 8'd1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd32000, 16'd32,
      32'd5, 8'd0, 8'd1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd30, 8'd0, 1'b1, TRUNC_HDR},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd48000, 16'd32,
      32'd1024, 8'd41, 8'd0, 1'b1, TRUNC_HDR},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 32'd16, 16'd3, 16'd1, 32'd96000, 16'd32,
      32'd4, 8'd0, 8'd0, 1'b0, NO_WANT}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  wav_chunk_header_parser_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #10 clk = ~clk;

  // header model state
  phase_e      wav_phase;
  logic [31:0] wav_pos;
  logic [31:0] wav_skip;
  int unsigned wav_fidx;
  logic [31:0] wav_tag_sr;
  logic [31:0] wav_len_sr;
  logic [15:0] wav_fmt_code;
  logic [15:0] wav_fmt_ch;
  logic [31:0] wav_fmt_rate;
  logic [15:0] wav_fmt_bits;
  logic        wav_seen_fmt;
  logic        wav_seen_data;
  logic        wav_done;
  logic [31:0] wav_d_size;
  logic [31:0] wav_d_off;
  logic        wav_riff_ok;

  out_item_t   pending_headers[$];
  out_item_t   head_want;
  logic        use_typed = 1'b0;
  out_item_t   typed_item = '0;
  logic [7:0]  file_q[$];

  int snd_idle;
  int rcv_idle;
  int stage;
  int fail_cnt = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int results_done = 0;
  int status_seen [5] = '{0, 0, 0, 0, 0};

  task automatic reset_header_model();
    wav_phase     = PH_RIFF;
    wav_pos       = '0;
    wav_skip      = '0;
    wav_fidx      = 0;
    wav_tag_sr    = '0;
    wav_len_sr    = '0;
    wav_fmt_code  = '0;
    wav_fmt_ch    = '0;
    wav_fmt_rate  = '0;
    wav_fmt_bits  = '0;
    wav_seen_fmt  = 1'b0;
    wav_seen_data = 1'b0;
    wav_done      = 1'b0;
    wav_d_size    = '0;
    wav_d_off     = '0;
    wav_riff_ok   = 1'b0;
  endtask

  function automatic status_e header_status();
    if (wav_fmt_code != FMT_FLOAT || wav_fmt_ch != MONO_CHANNELS ||
        wav_fmt_bits != FMT_FLOAT_BITS) return ST_UNSUPP;
    if (wav_d_size == '0) return ST_EMPTY;
    return ST_OK;
  endfunction

  task automatic parse_header_byte(input logic [7:0] b, input logic lst);
    out_item_t hdr;
    logic      fin;
    fin = 1'b0;
    case (wav_phase)
      PH_RIFF, PH_WAVE, PH_CID: begin
        wav_tag_sr = {b, wav_tag_sr[31:8]};
        wav_fidx++;
        if (wav_fidx >= 4) begin
          wav_fidx = 0;
          if (wav_phase == PH_RIFF) begin
            wav_riff_ok = (wav_tag_sr == TAG_RIFF);
            wav_phase = PH_RSIZE;
          end else if (wav_phase == PH_WAVE) begin
            wav_phase = (wav_riff_ok && wav_tag_sr == TAG_WAVE) ? PH_CID : PH_BAD;
          end else begin
            wav_phase = PH_CSIZE;
          end
        end
      end
      PH_RSIZE, PH_CSIZE: begin
        wav_len_sr = {b, wav_len_sr[31:8]};
        wav_fidx++;
        if (wav_fidx >= 4) begin
          wav_fidx = 0;
          if (wav_phase == PH_RSIZE) begin
            wav_phase = PH_WAVE;
          end else if (wav_tag_sr == TAG_FMT) begin
            wav_seen_fmt = 1'b1;
            {wav_fmt_code, wav_fmt_ch, wav_fmt_rate, wav_fmt_bits} = '0;
            wav_skip = (wav_len_sr > FMT_FIELD_BYTES) ? wav_len_sr - FMT_FIELD_BYTES : '0;
            wav_phase = PH_FMT;
          end else if (wav_tag_sr == TAG_DATA) begin
            wav_seen_data = 1'b1;
            wav_d_size = wav_len_sr;
            wav_d_off = wav_pos + 32'd1;
            if (wav_seen_fmt) begin
              fin = 1'b1;
            end else begin
              wav_skip = wav_len_sr;
              wav_phase = (wav_skip != '0) ? PH_SKIP : PH_CID;
            end
          end else begin
            wav_skip = wav_len_sr;
            wav_phase = (wav_skip != '0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_FMT: begin
        if (wav_fidx < 2) wav_fmt_code[8*wav_fidx +: 8] = b;
        else if (wav_fidx < 4) wav_fmt_ch[8*(wav_fidx-2) +: 8] = b;
        else if (wav_fidx < 8) wav_fmt_rate[8*(wav_fidx-4) +: 8] = b;
        else if (wav_fidx >= 14) wav_fmt_bits[8*(wav_fidx-14) +: 8] = b;
        wav_fidx++;
        if (wav_fidx >= 16) begin
          wav_fidx = 0;
          if (wav_seen_data) fin = 1'b1;
          else wav_phase = (wav_skip != '0) ? PH_SKIP : PH_CID;
        end
      end
      PH_SKIP: begin
        if (wav_skip != '0) wav_skip--;
        if (wav_skip == '0) wav_phase = PH_CID;
      end
      default: ;
    endcase
    wav_pos = wav_pos + 32'd1;
    if (fin) begin
      wav_done = 1'b1;
      wav_phase = PH_WAIT;
      hdr = '{header_status(), wav_fmt_code, wav_fmt_ch, wav_fmt_rate, wav_fmt_bits,
              wav_d_size, wav_d_off, wav_d_size[31:2]};
      pending_headers = {pending_headers, (use_typed ? typed_item : hdr)};
    end
    if (lst) begin
      if (!wav_done) begin
        hdr = '0;
        hdr.status = (wav_phase == PH_BAD) ? ST_BAD_TAGS : ST_TRUNCATED;
        pending_headers = {pending_headers, (use_typed ? typed_item : hdr)};
      end
      reset_header_model();
    end
  endtask

  task automatic emit_noise(input int unsigned n);
    repeat (n) file_q = {file_q, 8'($urandom)};
  endtask

  task automatic emit16(input logic [15:0] v);
    file_q = {file_q, v[7:0]};
    file_q = {file_q, v[15:8]};
  endtask

  task automatic emit32(input logic [31:0] v);
    emit16(v[15:0]);
    emit16(v[31:16]);
  endtask

  task automatic emit_fmt(input wav_file_t f, input logic scramble);
    emit32(TAG_FMT);
    emit32(f.fmt_len);
    emit16(f.fmt_code ^ {16{scramble}});
    emit16(f.fmt_ch ^ {16{scramble}});
    emit32(f.fmt_rate ^ {32{scramble}});
    emit32($urandom);
    emit16(16'($urandom));
    emit16(f.fmt_bits ^ {16{scramble}});
    if (f.fmt_len > FMT_FIELD_BYTES)
      emit_noise((f.fmt_len - FMT_FIELD_BYTES > 24) ? 24 : f.fmt_len - FMT_FIELD_BYTES);
  endtask

  task automatic emit_data(input logic [31:0] len, input logic with_body);
    emit32(TAG_DATA);
    emit32(len);
    if (with_body) emit_noise((len > 64) ? 64 : len);
  endtask

  task automatic build_file(input wav_file_t f);
    int unsigned n;
    file_q.delete();
    if (f.noise) begin
      n = $urandom_range(48, 1);
      if ($urandom_range(1) == 0) begin
        emit32(TAG_RIFF);
        emit32($urandom);
        emit32(TAG_WAVE);
      end
      while (file_q.size() < n) file_q = {file_q, 8'($urandom)};
    end else begin
      emit32(f.riff_bad ? TAG_RIFF ^ 32'h20 : TAG_RIFF);
      emit32($urandom);
      emit32(f.wave_bad ? TAG_WAVE ^ 32'h2000_0000 : TAG_WAVE);
      if (f.has_junk) begin
        emit32(TAG_LIST);
        emit32({24'd0, f.junk_len});
        emit_noise(f.junk_len);
      end
      if (f.data_first) begin
        if (f.dup) emit_data(f.data_len ^ 32'd3, 1'b1);
        emit_data(f.data_len, 1'b1);
        emit_fmt(f, 1'b0);
      end else begin
        if (f.dup) emit_fmt(f, 1'b1);
        emit_fmt(f, 1'b0);
        emit_data(f.data_len, 1'b0);
      end
      emit_noise(f.tail);
      if (f.cut != 0)
        while (file_q.size() > f.cut) void'(file_q.pop_back());
    end
  endtask

  function automatic wav_file_t random_file();
    wav_file_t f;
    f = '0;
    f.noise      = ($urandom_range(9) == 0);
    f.riff_bad   = ($urandom_range(24) == 0);
    f.wave_bad   = ($urandom_range(24) == 0);
    f.data_first = ($urandom_range(3) == 0);
    f.dup        = ($urandom_range(7) == 0);
    f.has_junk   = ($urandom_range(3) == 0);
    f.junk_len   = 8'($urandom_range(12));
    case ($urandom_range(9))
      0: f.fmt_len = $urandom_range(15);
      1: f.fmt_len = $urandom_range(24, 17);
      2: f.fmt_len = $urandom;
      default: f.fmt_len = FMT_FIELD_BYTES;
    endcase
    f.fmt_rate = $urandom;
    if ($urandom_range(4) != 0) begin
      f.fmt_code = FMT_FLOAT;
      f.fmt_ch   = MONO_CHANNELS;
      f.fmt_bits = FMT_FLOAT_BITS;
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: f.fmt_code = 16'($urandom);
          1: f.fmt_ch = 16'($urandom);
          default: f.fmt_bits = 16'($urandom);
        endcase
      end
    end else begin
      f.fmt_code = 16'($urandom);
      f.fmt_ch   = 16'($urandom);
      f.fmt_bits = 16'($urandom);
    end
    case ($urandom_range(7))
      0: f.data_len = '0;
      1: f.data_len = f.data_first ? $urandom_range(70) : $urandom;
      default: f.data_len = $urandom_range(48);
    endcase
    f.cut  = ($urandom_range(5) == 0) ? 8'($urandom_range(80, 1)) : 8'd0;
    f.tail = 8'($urandom_range(6));
    return f;
  endfunction

  task automatic set_idling(input int s);
    stage = s;
    case (s)
      0: begin
        snd_idle = 38;
        rcv_idle = 50;
      end
      1: begin
        snd_idle = 50;
        rcv_idle = 38;
      end
      default: begin
        snd_idle = 0;
        rcv_idle = 0;
      end
    endcase
  endtask

  task automatic put_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{file_byte: b, last_byte: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_header_byte(b, lst);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) put_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_headers.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < rcv_idle);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_headers.size() == 0) begin
        $error("header result with none pending, status %0d", out_item.status);
        fail_cnt++;
      end else begin
        head_want = pending_headers.pop_front();
        check_field("status", 32'(head_want.status), 32'(out_item.status));
        check_field("audio_format", 32'(head_want.audio_format),
                    32'(out_item.audio_format));
        check_field("channel_count", 32'(head_want.channel_count),
                    32'(out_item.channel_count));
        check_field("sample_rate", head_want.sample_rate, out_item.sample_rate);
        check_field("sample_bits", 32'(head_want.sample_bits), 32'(out_item.sample_bits));
        check_field("data_bytes", head_want.data_bytes, out_item.data_bytes);
        check_field("data_offset", head_want.data_offset, out_item.data_offset);
        check_field("float_count", 32'(head_want.float_count), 32'(out_item.float_count));
        results_done++;
        status_seen[int'(head_want.status)]++;
      end
    end
  end

  initial begin
    int dir_bytes;
    int span;
    int nxt;
    reset_header_model();
    set_idling(0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < $size(DIRECTED); i++) begin
      use_typed  = DIRECTED[i].typed;
      typed_item = DIRECTED[i].want;
      build_file(DIRECTED[i]);
      send_file();
    end
    use_typed = 1'b0;
    drain_results();
    dir_bytes = bytes_sent;
    span = (dir_bytes < 1400) ? (1550 - dir_bytes) / 3 : 50;
    while (bytes_sent - dir_bytes < 3 * span) begin
      nxt = (bytes_sent - dir_bytes < span) ? 0 : (bytes_sent - dir_bytes < 2 * span) ? 1 : 2;
      if (nxt != stage) begin
        drain_results();
        set_idling(nxt);
      end
      build_file(random_file());
      send_file();
    end
    drain_results();
    repeat (8) @(negedge clk);
    if (pending_headers.size() != 0) begin
      $error("%0d header results never arrived", pending_headers.size());
      fail_cnt++;
    end
    $display("Parsed %0d files (%0d bytes), %0d header results checked", files_sent,
             bytes_sent, results_done);
    $display("Status mix: ok %0d, unsupported %0d, bad tags %0d, truncated %0d, empty %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_cnt == 0) begin
      $display("tb_wav_chunk_header_parser_unit passed");
    end else begin
      $display("tb_wav_chunk_header_parser_unit failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_wav_chunk_header_parser_unit failed");
    $finish;
  end

endmodule
